// ===== sv/crc32fr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32fr_pkg
// Types, codes and the byte-wise CRC-32 update shared by the frame receiver.
// ----------------------------------------------------------------------------
package crc32fr_pkg;

   localparam logic [7:0]  START_BYTE        = 8'hAA;
   localparam logic [12:0] MAX_PAYLOAD_BYTES = 13'd4096;
   localparam logic [12:0] MAX_PAYLOAD_RST   = 13'd4096;
   localparam logic [15:0] IDLE_TIMEOUT_RST  = 16'd500;
   localparam logic [31:0] CRC_POLY          = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT          = 32'hFFFFFFFF;

   typedef enum logic [0:0] {
      CSR_MAX_PAYLOAD  = 1'b0,
      CSR_IDLE_TIMEOUT = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      REQ_BYTE = 1'b0,
      REQ_TICK = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      EV_PAYLOAD  = 3'd0,
      EV_ACCEPTED = 3'd1,
      EV_OVERFLOW = 3'd2,
      EV_CRC_BAD  = 3'd3,
      EV_TIMEOUT  = 3'd4
   } event_type;

   typedef enum logic [4:0] {
      PH_HUNT    = 5'b00001,
      PH_OPCODE  = 5'b00010,
      PH_LENGTH  = 5'b00100,
      PH_PAYLOAD = 5'b01000,
      PH_CRC     = 5'b10000
   } phase_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      event_type   event_res;
      logic [7:0]  opcode;
      logic [7:0]  payload_byte;
      logic [11:0] byte_index;
      logic [15:0] frame_length;
      logic        last;
   } result_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== sv/crc32_frame_receiver_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32_frame_receiver_top
// Deframer for 0xAA-started, length-prefixed frames closed by a CRC-32.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  req_     in         tdata: rx_byte; tuser: req_type (0 byte, 1 tick)
//  rsp_     out        tdata: opcode, payload_byte, byte_index, frame_length;
//                      tuser: event_res; tlast: last
//  csr_     in         write enable, register index, write data
//
//  One beat is taken every cycle while the result register is not stalled; a
//  request beat passes through the input register and then the result
//  register before its result is valid.
//  Synchronous reset restores max_payload 4096, idle_timeout 500 and hunting.
//  A stalled result register holds the core, and the input register keeps
//  taking a beat as long as the core moves on.
// ----------------------------------------------------------------------------
module crc32_frame_receiver_top import crc32fr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] rx_byte
   input  logic        req_tuser,  // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // [7:0] opcode, [15:8] payload_byte,
                                   // [27:16] byte_index, [43:28] frame_length
   output logic [2:0]  rsp_tuser,  // [2:0] event_res
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   item_type   in_item, item;
   logic       item_valid, step, res_valid;
   result_type res;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   assign in_item.req_type = req_tuser;
   assign in_item.rx_byte  = req_tdata;

   crc32fr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .take       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   assign step = item_valid && (!rsp_valid_ff || rsp_tready);

   crc32fr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index_type'(csr_index)),
      .csr_wdata (csr_wdata),
      .step      (step),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step && res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.event_res;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {4'd0, rsp_ff.frame_length, rsp_ff.byte_index,
                        rsp_ff.payload_byte, rsp_ff.opcode};

endmodule

// ===== sv/crc32fr_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32fr_in_stage
// Input register that holds one request beat until the core consumes it.
// ----------------------------------------------------------------------------
module crc32fr_in_stage import crc32fr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   input  logic     take,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff, valid_in;
   item_type item_ff;

   assign in_ready   = !valid_ff || take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

// ===== sv/crc32fr_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32fr_core
// Frame state, running CRC, idle counter and configuration registers; works
// out the next state and the optional result for one beat.
// ----------------------------------------------------------------------------
module crc32fr_core import crc32fr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  logic [15:0]   csr_wdata,
   input  logic          step,
   input  item_type      item,
   output logic          res_valid,
   output result_type    res
);

   logic [12:0] max_payload_ff;
   logic [15:0] idle_timeout_ff;
   phase_type   phase_ff, phase_in;
   logic [7:0]  opcode_ff, opcode_in;
   logic [7:0]  length_low_ff, length_low_in;
   logic [15:0] payload_len_ff, payload_len_in;
   logic [12:0] payload_count_ff, payload_count_in;
   logic [1:0]  fbc_ff, fbc_in;
   logic [31:0] rx_crc_ff, rx_crc_in;
   logic [31:0] crc_ff, crc_in;
   logic [15:0] idle_ff, idle_in;

   logic [31:0] crc_next;
   logic [15:0] idle_sat;
   logic [12:0] limit;
   logic [15:0] new_len;
   logic [12:0] count_inc;
   logic [31:0] rx_crc_new;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff  <= MAX_PAYLOAD_RST;
         idle_timeout_ff <= IDLE_TIMEOUT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_PAYLOAD:  max_payload_ff  <= csr_wdata[12:0];
            CSR_IDLE_TIMEOUT: idle_timeout_ff <= csr_wdata;
            default:          ;
         endcase
      end
   end

   assign crc_next   = crc_byte(crc_ff, item.rx_byte);
   assign idle_sat   = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
   assign limit      = (max_payload_ff > MAX_PAYLOAD_BYTES) ? MAX_PAYLOAD_BYTES
                                                           : max_payload_ff;
   assign new_len    = {item.rx_byte, length_low_ff};
   assign count_inc  = payload_count_ff + 13'd1;
   assign rx_crc_new = rx_crc_ff | ({24'd0, item.rx_byte} << {fbc_ff, 3'b000});

   always_comb begin
      phase_in         = phase_ff;
      opcode_in        = opcode_ff;
      length_low_in    = length_low_ff;
      payload_len_in   = payload_len_ff;
      payload_count_in = payload_count_ff;
      fbc_in           = fbc_ff;
      rx_crc_in        = rx_crc_ff;
      crc_in           = crc_ff;
      idle_in          = idle_ff;
      res_valid        = 1'b0;
      res.event_res    = EV_PAYLOAD;
      res.payload_byte = 8'd0;
      res.byte_index   = 12'd0;
      res.last         = 1'b0;

      if (item.req_type == REQ_TICK) begin
         if (phase_ff != PH_HUNT) begin
            idle_in = idle_sat;
            if (idle_sat >= idle_timeout_ff) begin
               phase_in      = PH_HUNT;
               fbc_in        = 2'd0;
               idle_in       = 16'd0;
               res_valid     = 1'b1;
               res.event_res = EV_TIMEOUT;
            end
         end
      end else begin
         idle_in = 16'd0;
         unique case (phase_ff)
            PH_HUNT: begin
               if (item.rx_byte == START_BYTE) begin
                  crc_in           = crc_byte(CRC_INIT, item.rx_byte);
                  opcode_in        = 8'd0;
                  length_low_in    = 8'd0;
                  payload_len_in   = 16'd0;
                  payload_count_in = 13'd0;
                  fbc_in           = 2'd0;
                  rx_crc_in        = 32'd0;
                  phase_in         = PH_OPCODE;
               end
            end
            PH_OPCODE: begin
               crc_in    = crc_next;
               opcode_in = item.rx_byte;
               fbc_in    = 2'd0;
               phase_in  = PH_LENGTH;
            end
            PH_LENGTH: begin
               crc_in = crc_next;
               if (fbc_ff == 2'd0) begin
                  length_low_in = item.rx_byte;
                  fbc_in        = 2'd1;
               end else begin
                  payload_len_in = new_len;
                  fbc_in         = 2'd0;
                  if (new_len > {3'd0, limit}) begin
                     phase_in      = PH_HUNT;
                     res_valid     = 1'b1;
                     res.event_res = EV_OVERFLOW;
                  end else begin
                     payload_count_in = 13'd0;
                     phase_in         = (new_len == 16'd0) ? PH_CRC : PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               crc_in           = crc_next;
               payload_count_in = count_inc;
               res_valid        = 1'b1;
               res.payload_byte = item.rx_byte;
               res.byte_index   = payload_count_ff[11:0];
               res.last         = ({3'd0, count_inc} >= payload_len_ff);
               if (res.last) begin
                  phase_in  = PH_CRC;
                  fbc_in    = 2'd0;
                  rx_crc_in = 32'd0;
               end
            end
            PH_CRC: begin
               rx_crc_in = rx_crc_new;
               if (fbc_ff != 2'd3) begin
                  fbc_in = fbc_ff + 2'd1;
               end else begin
                  phase_in      = PH_HUNT;
                  fbc_in        = 2'd0;
                  res_valid     = 1'b1;
                  res.event_res = ((crc_ff ^ CRC_INIT) == rx_crc_new) ? EV_ACCEPTED
                                                                      : EV_CRC_BAD;
               end
            end
            default: begin
               phase_in = PH_HUNT;
               fbc_in   = 2'd0;
            end
         endcase
      end

      res.opcode       = opcode_in;
      res.frame_length = payload_len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HUNT;
         opcode_ff        <= 8'd0;
         length_low_ff    <= 8'd0;
         payload_len_ff   <= 16'd0;
         payload_count_ff <= 13'd0;
         fbc_ff           <= 2'd0;
         rx_crc_ff        <= 32'd0;
         crc_ff           <= CRC_INIT;
         idle_ff          <= 16'd0;
      end else if (step) begin
         phase_ff         <= phase_in;
         opcode_ff        <= opcode_in;
         length_low_ff    <= length_low_in;
         payload_len_ff   <= payload_len_in;
         payload_count_ff <= payload_count_in;
         fbc_ff           <= fbc_in;
         rx_crc_ff        <= rx_crc_in;
         crc_ff           <= crc_in;
         idle_ff          <= idle_in;
      end
   end

endmodule

// ===== tb/tb_crc32_frame_receiver_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc32_frame_receiver_top
// Self-checking testbench for the CRC-32 frame receiver.
// A frame tracker follows the deframer state beat by beat and queues the
// events that each accepted request beat must produce. Every result beat is
// compared field by field with the oldest queued event. The stimulus starts
// with directed corner frames and continues with random well-formed,
// corrupted, oversized and truncated frames, noise and ticks under several
// register settings. Both channels insert random idle cycles, and one long
// receiver hold-off fills the block until it stalls its input.
// ----------------------------------------------------------------------------
module tb_crc32_frame_receiver_top;
   import crc32fr_pkg::*;

   localparam int WATCHDOG_CYCLES = 2000;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int DRAIN_CYCLES    = 8;
   localparam int RANDOM_BEATS    = 430;
   localparam int BEATS_PER_SETUP = 80;
   localparam int HOLD_OFF_LEN    = 64;

   class frame_event_tracker;
      logic [12:0] max_payload;
      logic [15:0] idle_timeout;
      phase_type   phase;
      logic [7:0]  opcode;
      logic [7:0]  length_low;
      logic [15:0] frame_length;
      logic [12:0] byte_count;
      logic [1:0]  field_count;
      logic [31:0] crc_seen;
      logic [31:0] crc_run;
      logic [15:0] idle_ticks;
      result_type  pending_events[$];
      int          errors;

      function new();
         max_payload  = MAX_PAYLOAD_RST;
         idle_timeout = IDLE_TIMEOUT_RST;
         phase        = PH_HUNT;
         opcode       = '0;
         length_low   = '0;
         frame_length = '0;
         byte_count   = '0;
         field_count  = '0;
         crc_seen     = '0;
         crc_run      = CRC_INIT;
         idle_ticks   = '0;
         errors       = 0;
      endfunction

      // Bit-serial form of the reflected CRC-32 update, LSB first.
      static function logic [31:0] crc32_next(logic [31:0] crc, logic [7:0] d);
         logic [31:0] c;
         logic        fb;
         c = crc;
         for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ d[i];
            c  = c >> 1;
            if (fb) c = c ^ CRC_POLY;
         end
         return c;
      endfunction

      function void write_reg(csr_index_type idx, logic [15:0] value);
         if (idx == CSR_MAX_PAYLOAD) max_payload = value[12:0];
         else idle_timeout = value;
      endfunction

      function void return_to_hunt();
         phase       = PH_HUNT;
         field_count = '0;
         idle_ticks  = '0;
      endfunction

      function void queue_event(event_type ev, logic [7:0] pb, logic [11:0] idx, logic lst);
         result_type r;
         r.event_res    = ev;
         r.opcode       = opcode;
         r.payload_byte = pb;
         r.byte_index   = idx;
         r.frame_length = frame_length;
         r.last         = lst;
         pending_events.push_back(r);
      endfunction

      function void absorb_beat(req_kind_type kind, logic [7:0] b);
         logic [12:0] lim;
         logic [11:0] idx;
         logic        lst;
         if (kind == REQ_TICK) begin
            if (phase == PH_HUNT) return;
            if (idle_ticks != 16'hFFFF) idle_ticks++;
            if (idle_ticks >= idle_timeout) begin
               return_to_hunt();
               queue_event(EV_TIMEOUT, 8'd0, 12'd0, 1'b0);
            end
            return;
         end
         idle_ticks = '0;
         case (phase)
            PH_HUNT: begin
               if (b == START_BYTE) begin
                  crc_run      = crc32_next(CRC_INIT, b);
                  opcode       = '0;
                  length_low   = '0;
                  frame_length = '0;
                  byte_count   = '0;
                  field_count  = '0;
                  crc_seen     = '0;
                  phase        = PH_OPCODE;
               end
            end
            PH_OPCODE: begin
               crc_run     = crc32_next(crc_run, b);
               opcode      = b;
               field_count = '0;
               phase       = PH_LENGTH;
            end
            PH_LENGTH: begin
               crc_run = crc32_next(crc_run, b);
               if (field_count == 2'd0) begin
                  length_low  = b;
                  field_count = 2'd1;
               end else begin
                  frame_length = {b, length_low};
                  field_count  = '0;
                  lim = (max_payload > MAX_PAYLOAD_BYTES) ? MAX_PAYLOAD_BYTES : max_payload;
                  if (frame_length > {3'd0, lim}) begin
                     return_to_hunt();
                     queue_event(EV_OVERFLOW, 8'd0, 12'd0, 1'b0);
                  end else begin
                     byte_count = '0;
                     phase = (frame_length == 16'd0) ? PH_CRC : PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               idx     = byte_count[11:0];
               crc_run = crc32_next(crc_run, b);
               byte_count++;
               lst = ({3'd0, byte_count} >= frame_length);
               if (lst) begin
                  phase       = PH_CRC;
                  field_count = '0;
                  crc_seen    = '0;
               end
               queue_event(EV_PAYLOAD, b, idx, lst);
            end
            PH_CRC: begin
               crc_seen = crc_seen | (32'(b) << (8 * field_count));
               if (field_count < 2'd3) begin
                  field_count++;
               end else begin
                  return_to_hunt();
                  if ((crc_run ^ CRC_INIT) == crc_seen)
                     queue_event(EV_ACCEPTED, 8'd0, 12'd0, 1'b0);
                  else
                     queue_event(EV_CRC_BAD, 8'd0, 12'd0, 1'b0);
               end
            end
            default: return_to_hunt();
         endcase
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void match_event(result_type got);
         result_type want;
         if (pending_events.size() == 0) begin
            $error("result beat with no event pending: event_res %0d", got.event_res);
            errors++;
            return;
         end
         want = pending_events.pop_front();
         compare_field("event_res", want.event_res, got.event_res);
         compare_field("opcode", want.opcode, got.opcode);
         compare_field("payload_byte", want.payload_byte, got.payload_byte);
         compare_field("byte_index", want.byte_index, got.byte_index);
         compare_field("frame_length", want.frame_length, got.frame_length);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we     = 1'b0;
   logic        csr_index  = 1'b0;
   logic [15:0] csr_wdata  = '0;

   frame_event_tracker tracker = new();
   bit          req_gaps    = 1'b1;
   bit          rsp_gaps    = 1'b1;
   bit          hold_off    = 1'b0;
   int          beats_sent  = 0;
   logic [12:0] cur_max     = MAX_PAYLOAD_RST;
   logic [15:0] cur_timeout = IDLE_TIMEOUT_RST;

   crc32_frame_receiver_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic send_beat(input req_kind_type kind, input logic [7:0] data);
      if (req_gaps && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      tracker.absorb_beat(kind, data);
      beats_sent++;
   endtask

   task automatic send_tick();
      send_beat(REQ_TICK, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_header(input logic [7:0] op, input logic [15:0] len);
      send_beat(REQ_BYTE, START_BYTE);
      send_beat(REQ_BYTE, op);
      send_beat(REQ_BYTE, len[7:0]);
      send_beat(REQ_BYTE, len[15:8]);
   endtask

   // A negative cut, or one no smaller than the frame, sends the whole frame; otherwise only its first cut bytes.
   task automatic send_frame(input logic [7:0] op, input int unsigned len, input bit bad_crc,
                             input int unsigned tick_max, input int cut);
      logic [7:0]  bytes[$];
      logic [31:0] crc;
      int          n;
      bytes.push_back(START_BYTE);
      bytes.push_back(op);
      bytes.push_back(8'(len));
      bytes.push_back(8'(len >> 8));
      repeat (len) bytes.push_back(8'($urandom_range(0, 255)));
      crc = CRC_INIT;
      foreach (bytes[i]) crc = frame_event_tracker::crc32_next(crc, bytes[i]);
      crc = crc ^ CRC_INIT;
      if (bad_crc) crc = crc ^ (32'd1 << $urandom_range(0, 31));
      for (int i = 0; i < 4; i++) bytes.push_back(8'(crc >> (8 * i)));
      n = (cut >= 0 && cut < bytes.size()) ? cut : bytes.size();
      for (int i = 0; i < n; i++) begin
         if (i > 0 && tick_max > 0 && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, tick_max)) send_tick();
         send_beat(REQ_BYTE, bytes[i]);
      end
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [15:0] value);
      req_tvalid <= 1'b0;
      while (tracker.pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.write_reg(idx, value);
   endtask

   task automatic set_config(input logic [12:0] max_len, input logic [15:0] timeout);
      write_csr(CSR_MAX_PAYLOAD, {3'd0, max_len});
      write_csr(CSR_IDLE_TIMEOUT, timeout);
      cur_max     = max_len;
      cur_timeout = timeout;
   endtask

   function automatic int unsigned payload_limit();
      return (cur_max > MAX_PAYLOAD_BYTES) ? int'(MAX_PAYLOAD_BYTES) : int'(cur_max);
   endfunction

   // Ticks per gap that keep a frame alive under the current timeout.
   function automatic int unsigned safe_ticks();
      if (cur_timeout < 16'd2) return 0;
      return (cur_timeout > 16'd4) ? 3 : int'(cur_timeout) - 1;
   endfunction

   function automatic logic [12:0] pick_max();
      case ($urandom_range(0, 5))
         0: return 13'd0;
         1: return 13'd1;
         2: return 13'd4096;
         3: return 13'd8191;
         4: return 13'($urandom_range(0, 64));
         default: return 13'($urandom_range(0, 4096));
      endcase
   endfunction

   function automatic logic [15:0] pick_timeout();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'd2;
         3: return 16'd65535;
         4: return 16'($urandom_range(1, 10));
         default: return 16'($urandom_range(1, 600));
      endcase
   endfunction

   task automatic random_sequence();
      int unsigned lim;
      int unsigned len;
      int unsigned pick;
      lim  = payload_limit();
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
         if ($urandom_range(0, 7) == 0) len = $urandom_range(0, (lim < 64) ? lim : 64);
         else len = $urandom_range(0, (lim < 8) ? lim : 8);
         send_frame(8'($urandom_range(0, 255)), len, $urandom_range(0, 3) == 0,
                    safe_ticks(), -1);
      end else if (pick == 6) begin
         len = ($urandom_range(0, 1) == 0) ? lim + 1 : $urandom_range(lim + 1, 65535);
         send_header(8'($urandom_range(0, 255)), 16'(len));
      end else if (pick == 7) begin
         len = $urandom_range(0, (lim < 8) ? lim : 8);
         if (cur_timeout <= 16'd20) begin
            send_frame(8'($urandom_range(0, 255)), len, 1'b0, 0,
                       $urandom_range(1, len + 7));
            repeat ((cur_timeout == 16'd0) ? 1 : cur_timeout) send_tick();
         end else begin
            send_frame(8'($urandom_range(0, 255)), len, 1'b1, safe_ticks(), -1);
         end
      end else if (pick == 8) begin
         repeat ($urandom_range(1, 5)) begin
            if ($urandom_range(0, 2) == 0) send_tick();
            else send_beat(REQ_BYTE, 8'($urandom_range(0, 255)));
         end
      end else begin
         repeat ($urandom_range(1, 3)) send_tick();
      end
   endtask

   initial begin : rsp_driver
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end else if (rsp_gaps && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.event_res    = event_type'(rsp_tuser);
         got.opcode       = rsp_tdata[7:0];
         got.payload_byte = rsp_tdata[15:8];
         got.byte_index   = rsp_tdata[27:16];
         got.frame_length = rsp_tdata[43:28];
         got.last         = rsp_tlast;
         tracker.match_event(got);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_CYCLES) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      int setup_end;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Noise and a tick while hunting, then short frames under reset settings.
      send_beat(REQ_BYTE, 8'h00);
      send_tick();
      send_frame(8'h00, 0, 1'b0, 0, -1);
      send_frame(8'hFF, 1, 1'b1, 0, -1);

      // A zero limit rejects any payload and a zero timeout aborts on the first tick.
      set_config(13'd0, 16'd0);
      send_header(8'h5A, 16'd1);
      send_beat(REQ_BYTE, START_BYTE);
      send_tick();

      set_config(13'd8191, 16'd65535);
      send_header(8'h11, 16'hFFFF);

      // Timeout in the middle of the length field.
      set_config(13'd2, 16'd2);
      send_frame(8'h33, 2, 1'b0, 0, 3);
      send_tick();
      send_tick();

      while (beats_sent < RANDOM_BEATS) begin
         set_config(pick_max(), pick_timeout());
         req_gaps  = ($urandom_range(0, 3) != 0);
         rsp_gaps  = ($urandom_range(0, 3) != 0);
         setup_end = beats_sent + BEATS_PER_SETUP;
         while (beats_sent < setup_end) random_sequence();
      end

      // A frame sent while the receiver holds off, so the input backs up.
      set_config(13'd4096, 16'd500);
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      hold_off = 1'b1;
      send_frame(8'($urandom_range(0, 255)), HOLD_OFF_LEN, 1'b0, 0, -1);

      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      set_config(13'($urandom_range(8, 64)), 16'($urandom_range(4, 20)));
      repeat (12) random_sequence();

      req_tvalid <= 1'b0;
      while (tracker.pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_events.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

// ===== crc32_frame_receiver_top.f =====
sv/crc32fr_pkg.sv
sv/crc32fr_in_stage.sv
sv/crc32fr_core.sv
sv/crc32_frame_receiver_top.sv
tb/tb_crc32_frame_receiver_top.sv
